// ===== src/ipv4p_pkg.sv =====
// Package for the IPv4 dotted-decimal parser: character codes, field
// widths, beat types and the decimal accumulate helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipv4p_pkg;

  localparam int unsigned CharW  = 16;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned OctetW = 10;

  typedef logic [CharW-1:0]  char_t;
  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [OctetW-1:0] octet_t;

  localparam char_t  ChNul    = 16'h0000;
  localparam char_t  ChDot    = 16'h002E;
  localparam char_t  ChZero   = 16'h0030;
  localparam char_t  ChNine   = 16'h0039;
  localparam octet_t OctetMax = 10'd255;

  // Character classes seen by the parse stage
  typedef enum logic [1:0] {
    CLS_NUL,
    CLS_DIGIT,
    CLS_DOT,
    CLS_OTHER
  } char_class_e;

  // One buffered character beat handed from the input register
  typedef struct packed {
    logic  valid;
    char_t code;
  } in_beat_t;

  // Accumulate one decimal digit: v * 10 + d, kept to the octet width
  function automatic octet_t dec_acc(input octet_t v, input logic [3:0] d);
    octet_t times8;
    octet_t times2;
    times8 = {v[OctetW-4:0], 3'b000};
    times2 = {v[OctetW-2:0], 1'b0};
    return octet_t'(times8 + times2 + {{(OctetW-4){1'b0}}, d});
  endfunction

endpackage

`default_nettype wire

// ===== src/ipv4p_char_if.sv =====
// Character channel: valid/ready handshake carrying one UCS-2 code per beat.
// Depends on ipv4p_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ipv4p_char_if import ipv4p_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

// ===== src/ipv4p_res_if.sv =====
// Result channel: valid/ready handshake carrying the parse verdict and address.
// Depends on ipv4p_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ipv4p_res_if import ipv4p_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  valid_res;
  addr_t address;

  modport source (output valid, output valid_res, output address, input ready);
  modport sink   (input valid, input valid_res, input address, output ready);
endinterface

`default_nettype wire

// ===== src/ipv4p_in_reg.sv =====
// Input register: captures one character beat and holds it until the
// parse stage consumes it. Depends on ipv4p_pkg and ipv4p_char_if.
`timescale 1ns / 1ps
`default_nettype none

module ipv4p_in_reg import ipv4p_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ipv4p_char_if.sink  char_i,
  input  wire logic   consume_i,
  output in_beat_t    beat_o
);

  logic  valid_q, valid_d;
  char_t code_q;
  logic  load;

  // Take a new beat when empty or when the held one leaves this cycle
  assign char_i.ready = !valid_q || consume_i;
  assign load         = char_i.valid && char_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the character payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q <= char_i.char_code;
    end
  end

  assign beat_o.valid = valid_q;
  assign beat_o.code  = code_q;

endmodule

`default_nettype wire

// ===== src/ipv4p_parse.sv =====
// Parse stage: per-string octet state, the one-character update and the
// result register. Depends on ipv4p_pkg and ipv4p_res_if.
`timescale 1ns / 1ps
`default_nettype none

module ipv4p_parse import ipv4p_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_beat_t beat_i,
  output logic          consume_o,
  ipv4p_res_if.source   res_o
);

  logic [1:0]  digit_cnt_q, digit_cnt_d;
  octet_t      octet_q, octet_d;
  logic [1:0]  octets_done_q, octets_done_d;
  logic [23:0] addr_q, addr_d;
  logic        err_q, err_d;

  logic        out_valid_q, out_valid_d;
  logic        out_ok_q;
  addr_t       out_addr_q;

  char_class_e cls;
  logic        out_free;
  logic        emit;
  logic        ok;
  logic        octet_big;

  // Classify the held character
  always_comb begin
    case (beat_i.code) inside
      ChNul:            cls = CLS_NUL;
      ChDot:            cls = CLS_DOT;
      [ChZero:ChNine]:  cls = CLS_DIGIT;
      default:          cls = CLS_OTHER;
    endcase
  end

  // A NUL needs room in the result register; other characters never wait
  assign out_free  = !out_valid_q || res_o.ready;
  assign consume_o = beat_i.valid && ((cls != CLS_NUL) || out_free);
  assign emit      = consume_o && (cls == CLS_NUL);

  assign octet_big = octet_q > OctetMax;
  assign ok        = !err_q && (octets_done_q == 2'd3) && (digit_cnt_q != 2'd0) &&
                     !octet_big;

  // Advance the octet state by one character
  always_comb begin
    digit_cnt_d   = digit_cnt_q;
    octet_d       = octet_q;
    octets_done_d = octets_done_q;
    addr_d        = addr_q;
    err_d         = err_q;
    if (consume_o) begin
      if (cls == CLS_NUL) begin
        digit_cnt_d   = '0;
        octet_d       = '0;
        octets_done_d = '0;
        addr_d        = '0;
        err_d         = 1'b0;
      end else if (!err_q) begin
        case (cls)
          CLS_DIGIT: begin
            if (digit_cnt_q == 2'd3) begin
              err_d = 1'b1;
            end else begin
              octet_d     = dec_acc(octet_q, beat_i.code[3:0]);
              digit_cnt_d = digit_cnt_q + 2'd1;
            end
          end
          CLS_DOT: begin
            if ((digit_cnt_q == 2'd0) || octet_big || (octets_done_q == 2'd3)) begin
              err_d = 1'b1;
            end else begin
              addr_d        = {addr_q[15:0], octet_q[7:0]};
              octets_done_d = octets_done_q + 2'd1;
              digit_cnt_d   = '0;
              octet_d       = '0;
            end
          end
          default: begin
            err_d = 1'b1;
          end
        endcase
      end
    end
  end

  // Result register valid: load on end of string, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_cnt_q   <= '0;
      octet_q       <= '0;
      octets_done_q <= '0;
      addr_q        <= '0;
      err_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      digit_cnt_q   <= digit_cnt_d;
      octet_q       <= octet_d;
      octets_done_q <= octets_done_d;
      addr_q        <= addr_d;
      err_q         <= err_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Hold the result payload; address reads zero when the string failed
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_ok_q   <= ok;
      out_addr_q <= ok ? {addr_q, octet_q[7:0]} : '0;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.valid_res = out_ok_q;
  assign res_o.address   = out_addr_q;

endmodule

`default_nettype wire

// ===== src/ipv4_dotted_address_parser.sv =====
// IPv4 dotted-decimal parser, one UCS-2 character per beat, one result per NUL.
// Path: a NUL passes through the input register, then the result register.
// Throughput: one character per cycle; the result register frees on the
// same edge it is taken, so a NUL stalls only while a result is unread.
// Reset (rst_ni low, asynchronous): both registers empty, string state cleared.
// Depends on ipv4p_pkg, ipv4p_char_if, ipv4p_res_if, ipv4p_in_reg, ipv4p_parse.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_dotted_address_parser import ipv4p_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ipv4p_char_if.sink   char_i,
  ipv4p_res_if.source  res_o
);

  in_beat_t beat;
  logic     consume;

  // Capture incoming character beats
  ipv4p_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .char_i    (char_i),
    .consume_i (consume),
    .beat_o    (beat)
  );

  // Update octet state and register the result
  ipv4p_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .consume_o (consume),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/ipv4p_verdict_checker.sv =====
// Verdict checker for the IPv4 dotted-decimal parser: watches both channels,
// predicts each verdict from the accepted characters and compares the results.
// Depends on ipv4p_pkg.
`timescale 1ns / 1ps

module ipv4p_verdict_checker import ipv4p_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         char_valid_i,
  input  wire logic         char_ready_i,
  input  wire char_t        char_code_i,
  input  wire logic         res_valid_i,
  input  wire logic         res_ready_i,
  input  wire logic         res_valid_res_i,
  input  wire addr_t        res_address_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       verdicts_pending_o
);

  typedef struct packed {
    logic  ok;
    addr_t addr;
  } verdict_t;

  // Verdicts predicted from NUL beats, oldest first
  verdict_t expected_verdicts[$];

  // Predicted string state
  logic [1:0] digit_cnt;
  octet_t     octet_acc;
  logic [2:0] octets_closed;
  addr_t      addr_acc;
  logic       err_flag;

  function automatic char_class_e classify(input char_t c);
    if (c == ChNul) return CLS_NUL;
    if (c >= ChZero && c <= ChNine) return CLS_DIGIT;
    if (c == ChDot) return CLS_DOT;
    return CLS_OTHER;
  endfunction

  task automatic clear_string();
    digit_cnt     = '0;
    octet_acc     = '0;
    octets_closed = '0;
    addr_acc      = '0;
    err_flag      = 1'b0;
  endtask

  // Advance the string state by one character; a NUL yields a verdict
  task automatic parse_char(input char_t c);
    verdict_t v;
    case (classify(c))
      CLS_NUL: begin
        v.ok   = !err_flag && octets_closed == 3'd3 && digit_cnt != 2'd0 &&
                 octet_acc <= OctetMax;
        v.addr = v.ok ? {addr_acc[23:0], octet_acc[7:0]} : '0;
        expected_verdicts.push_back(v);
        clear_string();
      end
      CLS_DIGIT: begin
        if (!err_flag) begin
          if (digit_cnt == 2'd3) begin
            err_flag = 1'b1;
          end else begin
            octet_acc = octet_t'(octet_acc * 10 + (c - ChZero));
            digit_cnt = digit_cnt + 2'd1;
          end
        end
      end
      CLS_DOT: begin
        if (!err_flag) begin
          if (digit_cnt == 2'd0 || octet_acc > OctetMax || octets_closed == 3'd3) begin
            err_flag = 1'b1;
          end else begin
            addr_acc      = {addr_acc[23:0], octet_acc[7:0]};
            octets_closed = octets_closed + 3'd1;
            digit_cnt     = '0;
            octet_acc     = '0;
          end
        end
      end
      default: begin
        err_flag = 1'b1;
      end
    endcase
  endtask

  // Compare result beats, then fold in character beats
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      clear_string();
      expected_verdicts.delete();
      mismatch_count_o   <= 0;
      verdicts_pending_o <= 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result beat: valid_res %0b, address %h",
                 res_valid_res_i, res_address_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = expected_verdicts.pop_front();
          if (res_valid_res_i !== want.ok) begin
            $error("valid_res mismatch: expected %0b, actual %0b",
                   want.ok, res_valid_res_i);
            mismatch_count_o <= mismatch_count_o + 1;
          end else if (res_address_i !== want.addr) begin
            $error("address mismatch: expected %h, actual %h",
                   want.addr, res_address_i);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      if (char_valid_i && char_ready_i) begin
        parse_char(char_code_i);
      end
      verdicts_pending_o <= expected_verdicts.size();
    end
  end

endmodule

// ===== tb/sv/ipv4_dotted_address_parser_tb.sv =====
// Top of the IPv4 dotted-decimal parser bench: clock, reset, character
// stimulus, result back-pressure and the final verdict. Depends on ipv4p_pkg,
// ipv4p_char_if, ipv4p_res_if, ipv4_dotted_address_parser, ipv4p_verdict_checker.
`timescale 1ns / 1ps

module ipv4_dotted_address_parser_tb import ipv4p_pkg::*; ();

  localparam int unsigned HalfPeriodNs = 5;
  localparam int unsigned ResetCycles  = 4;
  localparam int unsigned PhaseChars   = 110;
  localparam int unsigned DrainCycles  = 10;
  localparam int unsigned TimeoutNs    = 2_000_000;
  localparam char_t       CharAllOnes  = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned chars_sent    = 0;
  int unsigned mismatch_count;
  int unsigned verdicts_pending;

  ipv4p_char_if char_if ();
  ipv4p_res_if  res_if ();

  ipv4_dotted_address_parser dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .char_i (char_if),
    .res_o  (res_if)
  );

  ipv4p_verdict_checker chk (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .char_valid_i       (char_if.valid),
    .char_ready_i       (char_if.ready),
    .char_code_i        (char_if.char_code),
    .res_valid_i        (res_if.valid),
    .res_ready_i        (res_if.ready),
    .res_valid_res_i    (res_if.valid_res),
    .res_address_i      (res_if.address),
    .mismatch_count_o   (mismatch_count),
    .verdicts_pending_o (verdicts_pending)
  );

  always #(HalfPeriodNs) clk = ~clk;

  // Hard stop in case a handshake never completes
  initial begin
    #(TimeoutNs * 1ns);
    $display("Mismatches found");
    $finish;
  end

  // Redraw result back-pressure at random at each falling edge once out of reset
  initial begin
    res_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Drive one character beat, starting and ending at a falling edge
  task automatic send_char(input char_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      char_if.valid     <= 1'b0;
      char_if.char_code <= char_t'($urandom);
      @(negedge clk);
    end
    char_if.valid     <= 1'b1;
    char_if.char_code <= c;
    do @(posedge clk); while (!char_if.ready);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input char_t text[$]);
    foreach (text[k]) send_char(text[k]);
    send_char(ChNul);
  endtask

  task automatic send_text(input string s);
    char_t text[$];
    for (int k = 0; k < s.len(); k++) text.push_back(char_t'(s[k]));
    send_string(text);
  endtask

  // Mostly well-formed addresses with random octets, some mutated,
  // plus broken digit/dot runs and raw noise
  task automatic run_phase(input int unsigned src_pct, input int unsigned sink_pct);
    char_t       text[$];
    int unsigned start;
    int unsigned val;
    int unsigned need;
    int unsigned ndig;
    int unsigned scale;
    int unsigned pos;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    start         = chars_sent;
    while (chars_sent - start < PhaseChars) begin
      text = {};
      case ($urandom_range(9))
        7, 8: begin
          repeat ($urandom_range(8)) begin
            case ($urandom_range(3))
              0, 1: text.push_back(ChZero + char_t'($urandom_range(9)));
              2:    text.push_back(ChDot);
              default: text.push_back(char_t'($urandom));
            endcase
          end
        end
        9: begin
          repeat ($urandom_range(6, 1)) begin
            case ($urandom_range(3))
              0:       text.push_back(CharAllOnes);
              default: text.push_back(char_t'($urandom));
            endcase
          end
        end
        default: begin
          for (int o = 0; o < 4; o++) begin
            if (o > 0) text.push_back(ChDot);
            case ($urandom_range(9))
              0:       val = $urandom_range(999, 256);
              1:       val = 0;
              2:       val = 255;
              default: val = $urandom_range(255);
            endcase
            need = (val > 99) ? 3 : (val > 9) ? 2 : 1;
            ndig = $urandom_range(3, need);
            for (int k = ndig; k > 0; k--) begin
              scale = (k == 3) ? 100 : (k == 2) ? 10 : 1;
              text.push_back(ChZero + char_t'((val / scale) % 10));
            end
          end
          if ($urandom_range(3) == 0) begin
            pos = $urandom_range(text.size() - 1);
            case ($urandom_range(5))
              0: text.delete(pos);
              1: text.insert(pos, ChDot);
              2: text.insert(pos, ChZero + char_t'($urandom_range(9)));
              3: text.insert(pos, char_t'($urandom));
              4: text.push_back(ChDot);
              default: text = text[0:pos];
            endcase
          end
        end
      endcase
      send_string(text);
    end
  endtask

  // Reset, directed strings, three random phases, drain and verdict
  initial begin
    char_t text[$];
    char_if.valid     = 1'b0;
    char_if.char_code = '0;
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_text("");             // empty string
    send_text("255.0.0.07");   // top octet value, leading zero
    send_text("1.2.3.4.5");    // fourth dot, then ignored characters
    send_text("1234");         // fourth digit, too few octets
    send_text(".9");           // empty octet closed by a dot
    send_text("1.2.3.");       // empty last octet at end of string
    send_text("256.1");        // oversized octet closed by a dot
    send_text("9.9.9.999");    // oversized octet closed by end of string
    text = {CharAllOnes, ChZero};
    send_string(text);         // other character, then ignored digit

    run_phase(17, 67);
    run_phase(67, 17);
    run_phase(0, 0);

    char_if.valid <= 1'b0;
    while (verdicts_pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
